// ===== rtl/wrla_pkg.sv =====
// Package for the weighted region luma average unit.
// Holds command codes, register indexes, luma coefficients and the queue entry type.
// No dependencies.
package wrla_pkg;

  typedef enum logic [1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_TABLE_WR  = 2'd1,
    CMD_FRAME_END = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_CENTRE_X = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_REGION0  = 3'd3;

  localparam logic [15:0] LUMA_KR = 16'd13933;
  localparam logic [15:0] LUMA_KG = 16'd46871;
  localparam logic [15:0] LUMA_KB = 16'd4732;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] weight;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  tidx;
    logic [15:0] tval;
  } item_t;

endpackage

// ===== rtl/wrla_front.sv =====
// Front end: accepts items, looks up pixel region weights, drops zero-weight pixels and CMD_NONE.
// Depends on wrla_pkg.
module wrla_front #(
  parameter int NUM_REGIONS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [11:0]          in_pixel_x,
  input  logic [11:0]          in_pixel_y,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_table_index,
  input  logic [15:0]          in_table_value,
  input  logic [11:0]          centre_x,
  input  logic [11:0]          centre_y,
  input  logic [2:0]           region_count,
  input  logic [NUM_REGIONS*64-1:0] regions,
  output logic                 q_valid,
  output wrla_pkg::item_t      q_item,
  input  logic                 q_full
);
  import wrla_pkg::*;

  logic [15:0] weight;
  logic        found;
  logic signed [12:0] dx, dy;
  logic [3:0]  cnt;
  item_t       it;

  assign in_stall = q_full;
  assign dx = $signed({1'b0, in_pixel_x}) - $signed({1'b0, centre_x});
  assign dy = $signed({1'b0, in_pixel_y}) - $signed({1'b0, centre_y});
  assign cnt = ({1'b0, region_count} > 4'(NUM_REGIONS)) ? 4'(NUM_REGIONS)
                                                       : {1'b0, region_count};

  always_comb begin
    weight = '0;
    found  = 1'b0;
    for (int k = 0; k < NUM_REGIONS; k++) begin
      if (!found && 4'(k) < cnt &&
          dx >= -$signed({1'b0, regions[k*64 +: 12]}) &&
          dx <= $signed({1'b0, regions[k*64+12 +: 12]}) &&
          dy >= -$signed({1'b0, regions[k*64+24 +: 12]}) &&
          dy <= $signed({1'b0, regions[k*64+36 +: 12]})) begin
        found  = 1'b1;
        weight = regions[k*64+48 +: 16];
      end
    end
  end

  always_comb begin
    it.cmd    = cmd_t'(in_command);
    it.weight = weight;
    it.red    = in_red;
    it.green  = in_green;
    it.blue   = in_blue;
    it.tidx   = in_table_index;
    it.tval   = in_table_value;
  end

  assign q_item = it;
  // Zero-weight pixels and unknown commands are dropped here.
  assign q_valid = in_valid && !q_full &&
                   ((it.cmd == CMD_PIXEL && weight != 16'd0) ||
                    it.cmd == CMD_TABLE_WR || it.cmd == CMD_FRAME_END);

  logic unused;
  assign unused = clk ^ rst_n;
endmodule

// ===== rtl/wrla_queue.sv =====
// Short queue between the front and back ends.
// Depends on wrla_pkg.
module wrla_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  wrla_pkg::item_t wr_item,
  output logic            full,
  output logic            rd_valid,
  output wrla_pkg::item_t rd_item,
  input  logic            rd_take
);
  import wrla_pkg::*;

  item_t      mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full     = cnt_r == 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_valid) wp_r <= wp_r + 2'd1;
      if (rd_take)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_valid} - {2'd0, rd_take};
    end
  end
endmodule

// ===== rtl/wrla_back.sv =====
// Back end: gamma table, luma, accumulators and the frame-end serial divider.
// Depends on wrla_pkg.
module wrla_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  wrla_pkg::item_t q_item,
  output logic            q_take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_content_level
);
  import wrla_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t      state_r;
  logic [15:0] gamma_a_r [256];
  logic [15:0] gamma_b_r [256];
  logic [15:0] lr_r, lg_r, lb_r, w_r, w2_r;
  logic        rd_r;
  logic [33:0] acc_r;
  logic        acc_v_r;
  logic [63:0] sum_r;
  logic [39:0] tot_r;
  logic [63:0] dq_r;
  logic [40:0] rem_r;
  logic [39:0] div_r;
  logic [6:0]  bit_r;
  logic [15:0] res_r;
  logic [16:0] luma;
  logic [15:0] luma_sat;
  logic [40:0] trial;
  logic [41:0] rem2;
  logic [63:0] q;

  // Pixel path: table read, luma products, accumulate; a busy pipe holds frame end.
  wire is_fe  = q_item.cmd == CMD_FRAME_END;
  wire busy   = rd_r || acc_v_r;
  assign q_take = q_valid && state_r == ST_RUN && !(is_fe && busy);

  assign luma = 17'((acc_r + 34'd32768) >> 16);
  assign luma_sat = luma[16] ? 16'hFFFF : luma[15:0];
  assign rem2 = {rem_r, dq_r[63]};
  assign trial = 41'(rem2 - {2'b0, div_r});
  assign q = dq_r;

  always_ff @(posedge clk) begin
    // Two copies of the table serve the three channel reads of a pixel.
    if (q_take && q_item.cmd == CMD_TABLE_WR) begin
      gamma_a_r[q_item.tidx] <= q_item.tval;
      gamma_b_r[q_item.tidx] <= q_item.tval;
    end
    lr_r <= gamma_a_r[q_item.red];
    lg_r <= gamma_a_r[q_item.green];
    lb_r <= gamma_b_r[q_item.blue];
    w_r  <= q_item.weight;
    acc_r <= 34'({16'd0, LUMA_KR} * {16'd0, lr_r}) + 34'({16'd0, LUMA_KG} * {16'd0, lg_r})
           + 34'({16'd0, LUMA_KB} * {16'd0, lb_r});
    w2_r <= w_r;
    if (!rst_n) begin
      state_r <= ST_RUN; rd_r <= 1'b0; acc_v_r <= 1'b0;
      sum_r <= '0; tot_r <= '0; out_valid <= 1'b0;
    end else begin
      rd_r    <= q_take && q_item.cmd == CMD_PIXEL;
      acc_v_r <= rd_r;
      if (acc_v_r) begin
        sum_r <= sum_r + {32'd0, {16'd0, w2_r} * {16'd0, luma_sat}};
        tot_r <= tot_r + {24'd0, w2_r};
      end
      case (state_r)
        ST_RUN: if (q_take && is_fe) begin
          sum_r <= '0; tot_r <= '0;
          if (tot_r != 40'd0) begin
            dq_r <= sum_r; div_r <= tot_r; rem_r <= '0; bit_r <= 7'd64;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bit_r == 7'd0) begin
            // Round half up: r >= t - r, then saturate at 16'hFFFF.
            if ({rem_r, 1'b0} >= {1'b0, div_r})
              res_r <= (q >= 64'd65535) ? 16'hFFFF : 16'(q + 64'd1);
            else
              res_r <= (|q[63:16]) ? 16'hFFFF : q[15:0];
            state_r <= ST_OUT; out_valid <= 1'b1;
          end else begin
            if (!trial[40] && rem2[41] == 1'b0 || rem2[41]) begin
              rem_r <= rem2[41] ? 41'(rem2 - {2'b0, div_r}) : trial;
              dq_r <= {dq_r[62:0], 1'b1};
            end else begin
              rem_r <= rem2[40:0];
              dq_r <= {dq_r[62:0], 1'b0};
            end
            bit_r <= bit_r - 7'd1;
          end
        end
        ST_OUT: if (!out_stall) begin
          out_valid <= 1'b0; state_r <= ST_RUN;
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_content_level = res_r;
endmodule

// ===== rtl/weighted_region_luma_average_unit.sv =====
// Top level of the weighted region luma average unit.
// Instantiates wrla_front, wrla_queue and wrla_back; uses wrla_pkg.
//
// Input channel in_*: one item per cycle unless stalled. Pixels are tagged with
// the weight of the first containing rectangle; zero-weight ones are dropped.
// Gamma table writes go to two copies of a 256 x 16 memory in the back end.
// Frame end waits for the items ahead of it and for the two-stage pixel pipe to
// drain, then runs a 64-step bit-serial divider, and out_valid rises with the
// rounded, saturated result. A frame of zero total weight yields no result.
// Pixels go through one per cycle in ST_RUN; the divider sets the frame-end cost.
// A four-entry queue separates the front and back ends, so input keeps flowing
// until it fills. A stalled result holds and blocks the back end, and the input
// once the queue is full.
// Reset clears config, state and accumulators; the gamma table is undefined until
// written. Configuration is through the APB port, 64-bit registers at 8*i.
module weighted_region_luma_average_unit #(
  parameter int NUM_REGIONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_content_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import wrla_pkg::*;

  logic [11:0] cx_r, cy_r;
  logic [2:0]  rc_r;
  logic [NUM_REGIONS*64-1:0] reg_r;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; rc_r <= '0; reg_r <= '0;
    end else if (wr) begin
      if (idx == REG_CENTRE_X) cx_r <= pwdata[11:0];
      if (idx == REG_CENTRE_Y) cy_r <= pwdata[11:0];
      if (idx == REG_COUNT)    rc_r <= pwdata[2:0];
      for (int k = 0; k < NUM_REGIONS; k++)
        if (4'(idx) == 4'(k) + 4'(REG_REGION0)) reg_r[k*64 +: 64] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == REG_CENTRE_X) prdata = 64'(cx_r);
    if (idx == REG_CENTRE_Y) prdata = 64'(cy_r);
    if (idx == REG_COUNT)    prdata = 64'(rc_r);
    for (int k = 0; k < NUM_REGIONS; k++)
      if (4'(idx) == 4'(k) + 4'(REG_REGION0)) prdata = reg_r[k*64 +: 64];
  end

  logic  fq_valid, q_full, bq_valid, q_take;
  item_t fq_item, bq_item;

  wrla_front #(.NUM_REGIONS(NUM_REGIONS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_pixel_x, .in_pixel_y,
    .in_red, .in_green, .in_blue, .in_table_index, .in_table_value,
    .centre_x(cx_r), .centre_y(cy_r), .region_count(rc_r), .regions(reg_r),
    .q_valid(fq_valid), .q_item(fq_item), .q_full(q_full));

  wrla_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_item(fq_item), .full(q_full),
    .rd_valid(bq_valid), .rd_item(bq_item), .rd_take(q_take));

  wrla_back u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_item(bq_item), .q_take(q_take),
    .out_valid, .out_stall, .out_content_level);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_content_level))
    else $error("stalled result changed");
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !fq_valid) else $error("queue overflow");
endmodule

// ===== tb/sv/luma_average_checker.sv =====
// Checker for the weighted region luma average unit: tracks register writes and
// input transfers, predicts frame levels and compares result transfers.
// Depends on wrla_pkg.
`timescale 1ns / 1ps

module luma_average_checker
  import wrla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_content_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending_levels,
  output int          levels_checked,
  output int          transfers_seen
);

  logic [15:0] gamma_lin [256];
  logic [11:0] centre_col, centre_row;
  logic [2:0]  regions_used;
  logic [63:0] region_reg [4];
  logic [63:0] weighted_sum;
  logic [39:0] weight_total;
  logic [15:0] level_fifo [$];

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // The first rectangle that contains the pixel decides, even with weight zero.
  function automatic logic [15:0] region_weight(logic [11:0] x, logic [11:0] y);
    int dx, dy, n;
    logic [63:0] r;
    dx = int'(x) - int'(centre_col);
    dy = int'(y) - int'(centre_row);
    n = (regions_used > 3'd4) ? 4 : int'(regions_used);
    for (int k = 0; k < n; k++) begin
      r = region_reg[k];
      if (dx >= -int'(r[11:0]) && dx <= int'(r[23:12]) &&
          dy >= -int'(r[35:24]) && dy <= int'(r[47:36]))
        return r[63:48];
    end
    return 16'd0;
  endfunction

  function automatic logic [15:0] pixel_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [33:0] acc;
    logic [33:0] rounded;
    acc = 34'(LUMA_KR) * 34'(gamma_lin[r]) + 34'(LUMA_KG) * 34'(gamma_lin[g])
        + 34'(LUMA_KB) * 34'(gamma_lin[b]);
    rounded = (acc + 34'd32768) >> 16;
    return (rounded > 34'd65535) ? 16'hFFFF : rounded[15:0];
  endfunction

  function automatic logic [15:0] frame_level();
    logic [63:0] quo, rem, tot;
    tot = 64'(weight_total);
    quo = weighted_sum / tot;
    rem = weighted_sum % tot;
    if (rem >= tot - rem) quo++;
    return (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] w;
    logic [15:0] want;
    if (!rst_n) begin
      centre_col = '0;
      centre_row = '0;
      regions_used = '0;
      for (int k = 0; k < 4; k++) region_reg[k] = '0;
      weighted_sum = '0;
      weight_total = '0;
      level_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_CENTRE_X: centre_col = pwdata[11:0];
          REG_CENTRE_Y: centre_row = pwdata[11:0];
          REG_COUNT:    regions_used = pwdata[2:0];
          default: if (paddr[5:3] >= REG_REGION0 && paddr[5:3] < REG_REGION0 + 3'd4)
            region_reg[2'(paddr[5:3] - REG_REGION0)] = pwdata;
        endcase
      end
      if (in_valid && !in_stall) begin
        transfers_seen++;
        case (cmd_t'(in_command))
          CMD_PIXEL: begin
            w = region_weight(in_pixel_x, in_pixel_y);
            if (w != 16'd0) begin
              weighted_sum += 64'(w) * 64'(pixel_luma(in_red, in_green, in_blue));
              weight_total += 40'(w);
            end
          end
          CMD_TABLE_WR: gamma_lin[in_table_index] = in_table_value;
          CMD_FRAME_END: begin
            if (weight_total != '0) level_fifo.push_back(frame_level());
            weighted_sum = '0;
            weight_total = '0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (level_fifo.size() == 0) begin
          report_mismatch("unexpected content_level", out_content_level, 16'h0);
        end else begin
          want = level_fifo.pop_front();
          levels_checked++;
          if (out_content_level !== want)
            report_mismatch("content_level", out_content_level, want);
        end
      end
    end
    pending_levels = level_fifo.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the weighted region luma average testbench: clock, reset, stimulus and verdict.
// Depends on wrla_pkg, luma_average_checker and the unit under test.
`timescale 1ns / 1ps

module testbench;
  import wrla_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 125;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_NONE;
  logic [11:0] in_pixel_x = '0, in_pixel_y = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_table_index = '0;
  logic [15:0] in_table_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_content_level;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int mismatches, pending_levels, levels_checked, transfers_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  logic [11:0] cx_now, cy_now;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  weighted_region_luma_average_unit dut (.*);

  luma_average_checker checker_i (.*);

  always @(negedge clk) out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d levels outstanding", pending_levels);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send(cmd_t cmd, logic [11:0] x = 0, logic [11:0] y = 0,
                      logic [7:0] r = 0, logic [7:0] g = 0, logic [7:0] b = 0,
                      logic [7:0] idx = 0, logic [15:0] val = 0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_table_index <= idx;
    in_table_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // A frame end can produce nothing, so queued items may still be in flight here.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] random_region();
    logic [11:0] ext [4];
    logic [15:0] w;
    for (int k = 0; k < 4; k++)
      ext[k] = ($urandom_range(9) == 0) ? 12'hFFF : 12'($urandom_range(60));
    case ($urandom_range(7))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      default: w = 16'($urandom);
    endcase
    return {w, ext[3], ext[2], ext[1], ext[0]};
  endfunction

  task automatic configure(int phase);
    logic [2:0] count;
    case (phase)
      0: begin
        cx_now = 12'd2048;
        cy_now = 12'd2048;
        count = 3'd7;
      end
      3: begin
        cx_now = 12'd0;
        cy_now = 12'd0;
        count = 3'd0;
      end
      7: begin
        cx_now = 12'hFFF;
        cy_now = 12'hFFF;
        count = 3'd5;
      end
      default: begin
        cx_now = 12'($urandom);
        cy_now = 12'($urandom);
        count = 3'($urandom_range(1, 4));
      end
    endcase
    reg_write(REG_CENTRE_X, 64'(cx_now));
    reg_write(REG_CENTRE_Y, 64'(cy_now));
    reg_write(REG_COUNT, 64'(count));
    if (phase == 0) begin
      // A one-pixel hole of weight zero at the centre shadows the full-frame rectangles.
      reg_write(REG_REGION0, {16'h0000, 48'h0});
      reg_write(REG_REGION0 + 3'd1, {16'h0100, {4{12'hFFF}}});
      reg_write(REG_REGION0 + 3'd2, {16'hFFFF, {4{12'hFFF}}});
      reg_write(REG_REGION0 + 3'd3, {16'h0001, {4{12'hFFF}}});
    end else begin
      for (int k = 0; k < 4; k++) reg_write(REG_REGION0 + 3'(k), random_region());
    end
  endtask

  task automatic random_pixel();
    logic [11:0] x, y;
    if ($urandom_range(9) < 7) begin
      x = 12'(int'(cx_now) + $urandom_range(80) - 40);
      y = 12'(int'(cy_now) + $urandom_range(80) - 40);
    end else begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    send(CMD_PIXEL, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int sent;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      send_idle_pct = (phase % 4 == 1) ? 77 : (phase % 4 == 3) ? 23 : 0;
      stall_pct = (phase % 4 == 2) ? 77 : (phase % 4 == 3) ? 23 : 0;
      if (phase > 0) wait_quiet();
      configure(phase);
      sent = 0;
      if (phase == 0) begin
        // Every gamma entry is loaded before any pixel reads the table.
        for (int i = 0; i < 256; i++)
          send(CMD_TABLE_WR, .idx(8'(i)),
               .val(i == 255 ? 16'hFFFF : i == 0 ? 16'h0 : 16'($urandom)));
        send(CMD_PIXEL, 12'd2048, 12'd2048, 8'd255, 8'd255, 8'd255);
        send(CMD_FRAME_END);
        send(CMD_PIXEL, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
        send(CMD_PIXEL, 12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0);
        send(CMD_PIXEL, 12'd2049, 12'd2048, 8'd255, 8'd0, 8'd255);
        send(CMD_FRAME_END);
        send(CMD_FRAME_END);
        send(CMD_NONE, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send(CMD_TABLE_WR, .idx(8'd128), .val(16'hFFFF));
        send(CMD_PIXEL, 12'd2047, 12'd2047, 8'd128, 8'd128, 8'd128);
        send(CMD_PIXEL, 12'd100, 12'd4000, 8'd255, 8'd255, 8'd255);
        send(CMD_FRAME_END);
        send(CMD_PIXEL, 12'd2048, 12'd2048, 8'd255, 8'd255, 8'd255);
        send(CMD_FRAME_END);
        send(CMD_PIXEL, 12'd3000, 12'd5, 8'd1, 8'd2, 8'd3);
        send(CMD_FRAME_END);
      end
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0: send(CMD_NONE, 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 16'($urandom));
            1: send(CMD_TABLE_WR, .idx(8'($urandom)), .val(16'($urandom)));
            default: send(CMD_FRAME_END);
          endcase
          sent++;
        end else begin
          for (int n = $urandom_range(1, 12); n > 0; n--) begin
            random_pixel();
            sent++;
          end
          send(CMD_FRAME_END);
          sent++;
        end
      end
    end
    wait_quiet();
    $display("%0d input transfers over eight register settings and four idle patterns,",
             transfers_seen);
    $display("%0d frame levels compared.", levels_checked);
    if (mismatches == 0 && pending_levels == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
